// ----- hdl/bump_arena_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// bump_arena_allocator_defines
// Assertion macros used by the arena allocator checker.
// ----------------------------------------------------------------------------
`ifndef BUMP_ARENA_ALLOCATOR_DEFINES_SVH
`define BUMP_ARENA_ALLOCATOR_DEFINES_SVH

// property that must hold in the same cycle
`define BAA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// property whose consequent must hold in the next cycle
`define BAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/baa_pkg.sv -----
// ----------------------------------------------------------------------------
// baa_pkg
// Widths, command codes and transaction types of the arena allocator.
// ----------------------------------------------------------------------------
package baa_pkg;

	// arena geometry
	localparam int ADDR_WIDTH  = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int OFF_W       = ADDR_WIDTH + 1;
	localparam int CMD_W       = 2;
	localparam int ALIGN_W     = 4;
	localparam int ALIGN_MAX   = (1 << ALIGN_W) - 1;
	localparam int SUM_W       = ((OFF_W > ALIGN_MAX) ? OFF_W : ALIGN_MAX) + 2;
	localparam int CNT_OUT_W   = 32;
	localparam int BYTES_W     = 48;

	localparam logic [OFF_W-1:0] CAPACITY_RESET = OFF_W'(65536);

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESET   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [OFF_W-1:0]   size;
		logic [ALIGN_W-1:0] align_log2;
		logic [OFF_W-1:0]   block_offset;
	} req_t;

	typedef struct packed {
		logic                 status;
		logic [OFF_W-1:0]     start_offset;
		logic [OFF_W-1:0]     top_offset;
		logic                 freed;
		logic [CNT_OUT_W-1:0] alloc_count_out;
		logic [BYTES_W-1:0]   alloc_bytes_out;
		logic [CNT_OUT_W-1:0] free_count_out;
		logic [BYTES_W-1:0]   free_bytes_out;
	} rsp_t;

endpackage

// ----- hdl/baa_req_if.sv -----
// ----------------------------------------------------------------------------
// baa_req_if
// Request channel: command and operands of one allocator transaction.
// ----------------------------------------------------------------------------
interface baa_req_if;
	import baa_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [OFF_W-1:0]   size;
	logic [ALIGN_W-1:0] align_log2;
	logic [OFF_W-1:0]   block_offset;

	modport source (output valid, command, size, align_log2, block_offset, input ready);
	modport sink (input valid, command, size, align_log2, block_offset, output ready);
endinterface

// ----- hdl/baa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// baa_rsp_if
// Response channel: status, offsets and statistics of one transaction.
// ----------------------------------------------------------------------------
interface baa_rsp_if;
	import baa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 status;
	logic [OFF_W-1:0]     start_offset;
	logic [OFF_W-1:0]     top_offset;
	logic                 freed;
	logic [CNT_OUT_W-1:0] alloc_count_out;
	logic [BYTES_W-1:0]   alloc_bytes_out;
	logic [CNT_OUT_W-1:0] free_count_out;
	logic [BYTES_W-1:0]   free_bytes_out;

	modport source (output valid, status, start_offset, top_offset, freed, alloc_count_out,
		alloc_bytes_out, free_count_out, free_bytes_out, input ready);
	modport sink (input valid, status, start_offset, top_offset, freed, alloc_count_out,
		alloc_bytes_out, free_count_out, free_bytes_out, output ready);
endinterface

// ----- hdl/baa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// baa_cfg_if
// Configuration write channel carrying the arena capacity.
// ----------------------------------------------------------------------------
interface baa_cfg_if;
	import baa_pkg::*;

	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hdl/baa_in_stage.sv -----
// ----------------------------------------------------------------------------
// baa_in_stage
// Input register: captures one request transaction per cycle while the result stage is free.
// ----------------------------------------------------------------------------
module baa_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	baa_req_if.sink        req,
	input  logic           out_free,
	output logic           valid_s1,
	output baa_pkg::req_t  req_s1
);
	import baa_pkg::*;

	logic accept;

	// stage is free when empty or when it moves on this cycle
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.command      <= req.command;
			req_s1.size         <= req.size;
			req_s1.align_log2   <= req.align_log2;
			req_s1.block_offset <= req.block_offset;
		end
	end
endmodule

// ----- hdl/baa_core.sv -----
// ----------------------------------------------------------------------------
// baa_core
// Arena state, capacity register and the per-transaction update logic.
// ----------------------------------------------------------------------------
module baa_core (
	input  logic           clk,
	input  logic           arst_n,
	baa_cfg_if.sink        cfg,
	input  logic           fire,
	input  baa_pkg::req_t  req_s1,
	output baa_pkg::rsp_t  rsp_next
);
	import baa_pkg::*;

	logic [OFF_W-1:0]       capacity_q;
	logic [OFF_W-1:0]       top_q;
	logic [OFF_W-1:0]       prev_top_q;
	logic [OFF_W-1:0]       last_size_q;
	logic [COUNT_WIDTH-1:0] alloc_count_q;
	logic [BYTES_W-1:0]     alloc_bytes_q;
	logic [COUNT_WIDTH-1:0] free_count_q;
	logic [BYTES_W-1:0]     free_bytes_q;

	logic                   rel_en;
	logic                   alloc_en;
	logic                   clear_en;
	logic                   rel_hit;
	logic [OFF_W-1:0]       rel_bytes;
	logic [OFF_W-1:0]       top_mid;
	logic [SUM_W-1:0]       align_step;
	logic [SUM_W-1:0]       start_sum;
	logic [SUM_W-1:0]       end_sum;
	logic                   fit;
	logic                   alloc_ok;

	logic [OFF_W-1:0]       top_d;
	logic [OFF_W-1:0]       prev_top_d;
	logic [OFF_W-1:0]       last_size_d;
	logic [COUNT_WIDTH-1:0] alloc_count_d;
	logic [BYTES_W-1:0]     alloc_bytes_d;
	logic [COUNT_WIDTH-1:0] free_count_d;
	logic [BYTES_W-1:0]     free_bytes_d;

	assign cfg.ready = 1'b1;

	// command decode
	always_comb begin
		rel_en   = 1'b0;
		alloc_en = 1'b0;
		clear_en = 1'b0;
		case (req_s1.command)
			CMD_ALLOC: begin
				alloc_en = 1'b1;
			end
			CMD_DEALLOC: begin
				rel_en = 1'b1;
			end
			CMD_REALLOC: begin
				rel_en   = 1'b1;
				alloc_en = 1'b1;
			end
			default: begin
				clear_en = 1'b1;
			end
		endcase
	end

	// release of the most recent block
	assign rel_bytes = (req_s1.command == CMD_DEALLOC) ? req_s1.size : last_size_q;
	assign rel_hit   = rel_en && (top_q >= last_size_q)
		&& (req_s1.block_offset == (top_q - last_size_q));
	assign top_mid   = rel_hit ? prev_top_q : top_q;

	// aligned start and fit test at full width
	assign align_step = (SUM_W'(1) << req_s1.align_log2) - SUM_W'(1);
	assign start_sum  = (SUM_W'(top_mid) + align_step) & ~align_step;
	assign end_sum    = start_sum + SUM_W'(req_s1.size);
	assign fit        = end_sum <= SUM_W'(capacity_q);
	assign alloc_ok   = alloc_en && fit;

	// next state
	always_comb begin
		top_d         = top_mid;
		prev_top_d    = prev_top_q;
		last_size_d   = last_size_q;
		alloc_count_d = alloc_count_q;
		alloc_bytes_d = alloc_bytes_q;
		free_count_d  = free_count_q;
		free_bytes_d  = free_bytes_q;
		if (rel_en) begin
			free_count_d = free_count_q + COUNT_WIDTH'(1);
			free_bytes_d = free_bytes_q + BYTES_W'(rel_bytes);
		end
		if (alloc_ok) begin
			prev_top_d    = top_mid;
			last_size_d   = req_s1.size;
			top_d         = end_sum[OFF_W-1:0];
			alloc_count_d = alloc_count_q + COUNT_WIDTH'(1);
			alloc_bytes_d = alloc_bytes_q + BYTES_W'(req_s1.size);
		end
		if (clear_en) begin
			top_d         = '0;
			alloc_count_d = '0;
			alloc_bytes_d = '0;
			free_count_d  = '0;
			free_bytes_d  = '0;
		end
	end

	// result of the transaction
	always_comb begin
		rsp_next.status          = alloc_en && !fit;
		rsp_next.start_offset    = alloc_ok ? start_sum[OFF_W-1:0] : '0;
		rsp_next.top_offset      = top_d;
		rsp_next.freed           = rel_hit;
		rsp_next.alloc_count_out = CNT_OUT_W'(alloc_count_d);
		rsp_next.alloc_bytes_out = alloc_bytes_d;
		rsp_next.free_count_out  = CNT_OUT_W'(free_count_d);
		rsp_next.free_bytes_out  = free_bytes_d;
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.data;
		end
	end

	// arena state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q         <= '0;
			prev_top_q    <= '0;
			last_size_q   <= '0;
			alloc_count_q <= '0;
			alloc_bytes_q <= '0;
			free_count_q  <= '0;
			free_bytes_q  <= '0;
		end else if (fire) begin
			top_q         <= top_d;
			prev_top_q    <= prev_top_d;
			last_size_q   <= last_size_d;
			alloc_count_q <= alloc_count_d;
			alloc_bytes_q <= alloc_bytes_d;
			free_count_q  <= free_count_d;
			free_bytes_q  <= free_bytes_d;
		end
	end
endmodule

// ----- hdl/baa_out_stage.sv -----
// ----------------------------------------------------------------------------
// baa_out_stage
// Result register: holds one response transaction until it is taken.
// ----------------------------------------------------------------------------
module baa_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  baa_pkg::rsp_t  rsp_next,
	output logic           out_free,
	baa_rsp_if.source      rsp
);
	import baa_pkg::*;

	logic valid_q;
	rsp_t rsp_q;

	assign out_free = !valid_q || rsp.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && out_free) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.start_offset    = rsp_q.start_offset;
	assign rsp.top_offset      = rsp_q.top_offset;
	assign rsp.freed           = rsp_q.freed;
	assign rsp.alloc_count_out = rsp_q.alloc_count_out;
	assign rsp.alloc_bytes_out = rsp_q.alloc_bytes_out;
	assign rsp.free_count_out  = rsp_q.free_count_out;
	assign rsp.free_bytes_out  = rsp_q.free_bytes_out;
endmodule

// ----- hdl/bump_arena_allocator.sv -----
// Path: an accepted request is held in the input register, then its response is loaded into
// the result register; it waits longer only while an earlier response waits on rsp.ready.
// Throughput: one request per cycle unless a response waits on rsp.ready; the top -> align
// add -> fit compare -> top loop is combinational inside the core stage.
// Reset: arst_n clears top, previous top, last size, statistics and both stages at once;
// capacity returns to 65536.
// ----------------------------------------------------------------------------
// bump_arena_allocator
// Bump-pointer arena allocator with alignment, release of the last block
// and allocation statistics.
// ----------------------------------------------------------------------------
module bump_arena_allocator (
	input  logic      clk,
	input  logic      arst_n,
	baa_req_if.sink   req,
	baa_rsp_if.source rsp,
	baa_cfg_if.sink   cfg
);
	import baa_pkg::*;

	logic valid_s1;
	logic out_free;
	logic fire;
	req_t req_s1;
	rsp_t rsp_next;

	// transaction leaves the input register
	assign fire = valid_s1 && out_free;

	baa_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	baa_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (fire),
		.req_s1   (req_s1),
		.rsp_next (rsp_next)
	);

	baa_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.rsp_next (rsp_next),
		.out_free (out_free),
		.rsp      (rsp)
	);
endmodule

// ----- hdl/baa_checker.sv -----
// ----------------------------------------------------------------------------
// baa_checker
// Port-level checks of the arena allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bump_arena_allocator_defines.svh"

module baa_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  out_status,
	input logic [baa_pkg::OFF_W-1:0] out_start,
	input logic [baa_pkg::OFF_W-1:0] out_top
);
	import baa_pkg::*;

	// request side only stalls behind a stalled response
	`BAA_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready), "request stalled without response backpressure")

	// a new response needs a request accepted into the input register, then moved to the result register
	`BAA_ASSERT(a_rsp_origin, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "response appeared without a request")

	// response held while stalled
	`BAA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid, "response dropped while stalled")

	// response payload held while stalled
	`BAA_ASSERT_NEXT(a_rsp_stable, clk, arst_n, out_valid && !out_ready, $stable(out_status) && $stable(out_start) && $stable(out_top), "response payload changed while stalled")
endmodule

bind bump_arena_allocator baa_checker u_baa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_start  (rsp.start_offset),
	.out_top    (rsp.top_offset)
);

// ----- verif/bump_arena_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_arena_allocator_test
// Self-checking bench for the arena allocator. A directed opening covers the
// corner cases: exact fit, oversize requests, widest alignment, roll-back
// of the newest block, foreign offsets, a reallocation whose placement fails
// and a wipe that keeps the roll-back record. After that, random request
// streams run over several capacity settings. Each transaction's reply is
// predicted and compared field by field, with random idling on both
// channels and one long stall on the reply side.
// ----------------------------------------------------------------------------
module bump_arena_allocator_test;
	import baa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [OFF_W-1:0]     cap;
		logic [OFF_W-1:0]     top;
		logic [OFF_W-1:0]     prev_top;
		logic [OFF_W-1:0]     last_size;
		logic [CNT_OUT_W-1:0] alloc_count;
		logic [BYTES_W-1:0]   alloc_bytes;
		logic [CNT_OUT_W-1:0] free_count;
		logic [BYTES_W-1:0]   free_bytes;
	} arena_state_t;

	logic clk = 1'b0;
	logic arst_n;

	baa_req_if req_ch ();
	baa_rsp_if rsp_ch ();
	baa_cfg_if cfg_ch ();

	bump_arena_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// arena as seen by the stimulus (plan) and by the checker (live)
	arena_state_t plan;
	arena_state_t live;

	req_t pending_requests[$];
	rsp_t expected_replies[$];

	bit req_hs     = 1'b0;
	bit rsp_hs     = 1'b0;
	bit quiet      = 1'b0;
	int req_wait   = 0;
	int rsp_wait   = 0;
	int hold_asks  = 0;
	int hold_given = 0;
	int hold_left  = 0;
	int cycles     = 0;
	int faults     = 0;
	int placed     = 0;
	int oom        = 0;
	int rollbacks  = 0;
	int wipes      = 0;
	int settings   = 0;
	int replies    = 0;

	function automatic arena_state_t fresh_arena();
		arena_state_t s;
		s.cap         = CAPACITY_RESET;
		s.top         = '0;
		s.prev_top    = '0;
		s.last_size   = '0;
		s.alloc_count = '0;
		s.alloc_bytes = '0;
		s.free_count  = '0;
		s.free_bytes  = '0;
		return s;
	endfunction

	// roll top back if the offset names the newest block, always counted
	function automatic logic release_last(inout arena_state_t s,
		input logic [OFF_W-1:0] off, input logic [OFF_W-1:0] bytes);
		logic hit;
		hit = (s.top >= s.last_size) && (off == s.top - s.last_size);
		if (hit)
			s.top = s.prev_top;
		s.free_count = s.free_count + CNT_OUT_W'(1);
		s.free_bytes = s.free_bytes + BYTES_W'(bytes);
		return hit;
	endfunction

	// aligned placement, fit test at full width so no sum wraps
	function automatic logic place_block(inout arena_state_t s,
		input logic [OFF_W-1:0] bytes, input logic [ALIGN_W-1:0] lg,
		output logic [OFF_W-1:0] start_out);
		logic [OFF_W+2:0] mask;
		logic [OFF_W+2:0] start;
		logic [OFF_W+2:0] stop;
		mask  = ((OFF_W+3)'(1) << lg) - (OFF_W+3)'(1);
		start = ({3'b000, s.top} + mask) & ~mask;
		stop  = start + {3'b000, bytes};
		if (stop > {3'b000, s.cap}) begin
			start_out = '0;
			return 1'b0;
		end
		s.prev_top    = s.top;
		s.last_size   = bytes;
		s.top         = stop[OFF_W-1:0];
		s.alloc_count = s.alloc_count + CNT_OUT_W'(1);
		s.alloc_bytes = s.alloc_bytes + BYTES_W'(bytes);
		start_out     = start[OFF_W-1:0];
		return 1'b1;
	endfunction

	// one request applied to an arena, giving the reply it must produce
	function automatic rsp_t bump_step(inout arena_state_t s, input req_t r);
		rsp_t o;
		logic [OFF_W-1:0] start;
		o     = '0;
		start = '0;
		case (r.command)
			CMD_ALLOC: begin
				o.status = !place_block(s, r.size, r.align_log2, start);
			end
			CMD_DEALLOC: begin
				o.freed = release_last(s, r.block_offset, r.size);
			end
			CMD_REALLOC: begin
				o.freed  = release_last(s, r.block_offset, s.last_size);
				o.status = !place_block(s, r.size, r.align_log2, start);
			end
			CMD_RESET: begin
				s.top         = '0;
				s.alloc_count = '0;
				s.alloc_bytes = '0;
				s.free_count  = '0;
				s.free_bytes  = '0;
			end
			default: begin
			end
		endcase
		o.start_offset    = start;
		o.top_offset      = s.top;
		o.alloc_count_out = s.alloc_count;
		o.alloc_bytes_out = s.alloc_bytes;
		o.free_count_out  = s.free_count;
		o.free_bytes_out  = s.free_bytes;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				want, got);
			faults++;
		end
	endfunction

	function automatic void check_reply(input rsp_t got);
		rsp_t want;
		if (expected_replies.size() == 0) begin
			$display("%0t ns: reply with none outstanding, expected nothing, actual %p",
				$time, got);
			faults++;
			return;
		end
		want = expected_replies.pop_front();
		check_field("status", 64'(want.status), 64'(got.status));
		check_field("start_offset", 64'(want.start_offset), 64'(got.start_offset));
		check_field("top_offset", 64'(want.top_offset), 64'(got.top_offset));
		check_field("freed", 64'(want.freed), 64'(got.freed));
		check_field("alloc_count_out", 64'(want.alloc_count_out),
			64'(got.alloc_count_out));
		check_field("alloc_bytes_out", 64'(want.alloc_bytes_out),
			64'(got.alloc_bytes_out));
		check_field("free_count_out", 64'(want.free_count_out),
			64'(got.free_count_out));
		check_field("free_bytes_out", 64'(want.free_bytes_out),
			64'(got.free_bytes_out));
	endfunction

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic req_t mk(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] sz,
		input logic [ALIGN_W-1:0] lg, input logic [OFF_W-1:0] off);
		req_t r;
		r.command      = cmd;
		r.size         = sz;
		r.align_log2   = lg;
		r.block_offset = off;
		return r;
	endfunction

	// offset of the newest block as the stimulus side sees it
	function automatic logic [OFF_W-1:0] newest_block();
		return (plan.top >= plan.last_size) ? plan.top - plan.last_size : '0;
	endfunction

	// sample both channels on the rising edge and predict accepted requests
	always @(posedge clk) begin : monitor
		req_t taken;
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			req_hs <= req_ch.valid && req_ch.ready;
			rsp_hs <= rsp_ch.valid && rsp_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status          = rsp_ch.status;
				got.start_offset    = rsp_ch.start_offset;
				got.top_offset      = rsp_ch.top_offset;
				got.freed           = rsp_ch.freed;
				got.alloc_count_out = rsp_ch.alloc_count_out;
				got.alloc_bytes_out = rsp_ch.alloc_bytes_out;
				got.free_count_out  = rsp_ch.free_count_out;
				got.free_bytes_out  = rsp_ch.free_bytes_out;
				check_reply(got);
				replies++;
			end
			if (req_ch.valid && req_ch.ready) begin
				taken = pending_requests.pop_front();
				want  = bump_step(live, taken);
				expected_replies.push_back(want);
				if (taken.command == CMD_ALLOC || taken.command == CMD_REALLOC) begin
					if (want.status)
						oom++;
					else
						placed++;
				end
				if (want.freed)
					rollbacks++;
				if (taken.command == CMD_RESET)
					wipes++;
			end
		end
	end

	// request driver, fed from the pending queue
	always @(negedge clk) begin : req_driver
		if (req_hs)
			req_wait = draw_wait();
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_wait > 0) begin
			req_wait--;
			req_ch.valid <= 1'b0;
		end else if (pending_requests.size() > 0) begin
			req_ch.valid        <= 1'b1;
			req_ch.command      <= pending_requests[0].command;
			req_ch.size         <= pending_requests[0].size;
			req_ch.align_log2   <= pending_requests[0].align_log2;
			req_ch.block_offset <= pending_requests[0].block_offset;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// long reply stall, counted here
	always @(negedge clk) begin : rsp_hold
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_given) begin
			hold_left  <= HOLD_CYCLES;
			hold_given <= hold_asks;
		end
	end

	// reply side back-pressure
	always @(negedge clk) begin : rsp_receiver
		if (rsp_hs)
			rsp_wait = draw_wait();
		if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= (hold_left == 0);
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("bump_arena_allocator test failed");
			$finish;
		end
	end

	task automatic offer(input req_t r);
		void'(bump_step(plan, r));
		pending_requests.push_back(r);
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_requests.size() != 0 || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	// capacity write, only while the block is idle
	task automatic write_capacity(input logic [OFF_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		plan.cap = value;
		live.cap = value;
		settings++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly well-formed alloc and release chains, with foreign offsets and wipes
	task automatic random_phase(input logic [OFF_W-1:0] cap_value, input int count,
		input bit calm, input bit with_hold);
		req_t r;
		int pick;
		drain();
		write_capacity(cap_value);
		@(posedge clk);
		quiet = calm;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				r.size = OFF_W'($urandom_range(0, 64));
			else if (pick < 8)
				r.size = OFF_W'($urandom_range(0, plan.cap / 8));
			else if (pick < 9)
				r.size = OFF_W'($urandom_range(0, plan.cap));
			else
				r.size = OFF_W'($urandom_range(0, 17'h1FFFF));
			r.align_log2   = ($urandom_range(0, 9) < 7) ? ALIGN_W'($urandom_range(0, 4))
				: ALIGN_W'($urandom_range(0, 15));
			r.block_offset = OFF_W'($urandom_range(0, 17'h1FFFF));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r.command = CMD_ALLOC;
			end else if (pick < 65) begin
				r.command      = CMD_DEALLOC;
				r.block_offset = newest_block();
				if (pick < 58)
					r.size = plan.last_size;
			end else if (pick < 73) begin
				r.command = CMD_DEALLOC;
			end else if (pick < 88) begin
				r.command      = CMD_REALLOC;
				r.block_offset = newest_block();
			end else if (pick < 95) begin
				r.command = CMD_REALLOC;
			end else begin
				r.command = CMD_RESET;
			end
			offer(r);
		end
		if (with_hold)
			hold_asks++;
	endtask

	initial begin : main
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_ALLOC;
		req_ch.size         = '0;
		req_ch.align_log2   = '0;
		req_ch.block_offset = '0;
		rsp_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;
		plan = fresh_arena();
		live = fresh_arena();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed opening at the reset capacity
		@(posedge clk);
		offer(mk(CMD_ALLOC, 17'd0, 4'd0, 17'd0));
		offer(mk(CMD_ALLOC, 17'd100, 4'd0, 17'h1FFFF));
		offer(mk(CMD_ALLOC, 17'd50, 4'd4, 17'd0));
		offer(mk(CMD_DEALLOC, 17'd50, 4'd0, newest_block()));
		offer(mk(CMD_DEALLOC, 17'h1FFFF, 4'd15, 17'h1FFFF));
		offer(mk(CMD_REALLOC, 17'd20, 4'd3, newest_block()));
		offer(mk(CMD_REALLOC, 17'h1FFFF, 4'd15, 17'd0));
		offer(mk(CMD_ALLOC, 17'd1, 4'd15, 17'd0));
		offer(mk(CMD_ALLOC, 17'd65536, 4'd0, 17'd0));
		offer(mk(CMD_ALLOC, 17'h1FFFF, 4'd0, 17'd0));
		// wipe keeps the roll-back record, so last size now exceeds top
		offer(mk(CMD_RESET, 17'h1FFFF, 4'd15, 17'h1FFFF));
		offer(mk(CMD_DEALLOC, 17'd0, 4'd0, 17'd0));
		// exact fit, then a zero-sized block at the very end
		offer(mk(CMD_ALLOC, 17'd65536, 4'd0, 17'd0));
		offer(mk(CMD_ALLOC, 17'd0, 4'd15, 17'd0));
		offer(mk(CMD_ALLOC, 17'd1, 4'd0, 17'd0));
		offer(mk(CMD_DEALLOC, 17'd0, 4'd0, newest_block()));
		offer(mk(CMD_RESET, 17'd0, 4'd0, 17'd0));

		// empty arena
		drain();
		write_capacity(17'd0);
		@(posedge clk);
		offer(mk(CMD_ALLOC, 17'd0, 4'd15, 17'd0));
		offer(mk(CMD_ALLOC, 17'd1, 4'd0, 17'd0));
		offer(mk(CMD_REALLOC, 17'd0, 4'd2, newest_block()));

		// widest register value, alignment pushes start past the limit
		drain();
		write_capacity(17'h1FFFF);
		@(posedge clk);
		offer(mk(CMD_RESET, 17'd0, 4'd0, 17'd0));
		offer(mk(CMD_ALLOC, 17'h1FFFF, 4'd0, 17'd0));
		offer(mk(CMD_ALLOC, 17'd0, 4'd1, 17'd0));
		offer(mk(CMD_DEALLOC, 17'h1FFFF, 4'd0, newest_block()));

		// random streams over several capacities
		random_phase(17'd65536, 235, 1'b0, 1'b0);
		random_phase(OFF_W'($urandom_range(1, 512)), 235, 1'b0, 1'b1);
		random_phase(17'h1FFFF, 235, 1'b1, 1'b0);
		random_phase(OFF_W'($urandom_range(0, 17'h1FFFF)), 235, 1'b0, 1'b0);
		random_phase(17'd0, 50, 1'b0, 1'b0);
		random_phase(17'd65536, 235, 1'b0, 1'b0);

		// let any stray reply show up before closing
		drain();
		repeat (8) @(negedge clk);

		$display("checked %0d replies over %0d capacity settings, one long reply stall",
			replies, settings);
		$display("placements %0d, out of memory %0d, roll-backs %0d, arena wipes %0d",
			placed, oom, rollbacks, wipes);
		if (faults == 0)
			$display("bump_arena_allocator test passed");
		else
			$display("bump_arena_allocator test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/baa_pkg.sv
hdl/baa_req_if.sv
hdl/baa_rsp_if.sv
hdl/baa_cfg_if.sv
hdl/baa_in_stage.sv
hdl/baa_core.sv
hdl/baa_out_stage.sv
hdl/bump_arena_allocator.sv
hdl/baa_checker.sv
verif/bump_arena_allocator_test.sv
